// ===== rtl/rvz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvz_pkg
// Shared constants, types and the CORDIC arctangent table for the Z-axis
// vector rotator.
// ----------------------------------------------------------------------------
package rvz_pkg;

    // Default field widths (components carry 12 fraction bits by convention)
    localparam int COMPONENT_WIDTH_DEF = 24;
    localparam int ANGLE_WIDTH_DEF     = 16;

    // CORDIC datapath: angles in 2^32 units per turn, trig values in Q2.30
    localparam int TRIG_W       = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_SHIFT   = 30;
    localparam int SPLIT_BITS   = 24;

    // K * 2^30, gain of the 30-step CORDIC folded into the start value
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // Control tag that travels with every pipeline stage
    typedef struct packed {
        logic valid;  // stage holds an item
        logic flip;   // angle was folded by pi, negate sin and cos
    } t_tag;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic signed [TRIG_W-1:0] atan_step(input int step);
        logic signed [TRIG_W-1:0] v;
        case (step)
            0:       v = 32'sd536870912;
            1:       v = 32'sd316933406;
            2:       v = 32'sd167458907;
            3:       v = 32'sd85004756;
            4:       v = 32'sd42667331;
            5:       v = 32'sd21354465;
            6:       v = 32'sd10679838;
            7:       v = 32'sd5340245;
            8:       v = 32'sd2670163;
            9:       v = 32'sd1335087;
            10:      v = 32'sd667544;
            11:      v = 32'sd333772;
            12:      v = 32'sd166886;
            13:      v = 32'sd83443;
            14:      v = 32'sd41722;
            15:      v = 32'sd20861;
            16:      v = 32'sd10430;
            17:      v = 32'sd5215;
            18:      v = 32'sd2608;
            19:      v = 32'sd1304;
            20:      v = 32'sd652;
            21:      v = 32'sd326;
            22:      v = 32'sd163;
            23:      v = 32'sd81;
            24:      v = 32'sd41;
            25:      v = 32'sd20;
            26:      v = 32'sd10;
            27:      v = 32'sd5;
            28:      v = 32'sd3;
            29:      v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/rotate_vector_about_z.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_vector_about_z
// Rotates a 3D fixed-point vector counter-clockwise about Z by a binary
// angle. Pipelined CORDIC for sin/cos, then rounded, saturated products.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake               Content
//  s_axis    in   i_s_tvalid/o_s_tready   x_in, y_in, z_in, angle
//  m_axis    out  o_m_tvalid/i_m_tready   x_out, y_out, z_out
//
//  One item per cycle while the skid entry is free; 37 register stages (input
//  fold, 30 CORDIC stages, 5 multiply/round stages, out) lie between s_axis
//  and m_axis.
//  The 30 CORDIC micro-rotations, one per stage, set the depth.
//  Reset (i_rst_n low, synchronous) empties the pipeline and output.
//  On stall an output register plus one skid entry absorb results; the
//  pipeline halts only when the skid entry is full.
// ----------------------------------------------------------------------------
module rotate_vector_about_z #(
    parameter int COMPONENT_WIDTH = rvz_pkg::COMPONENT_WIDTH_DEF,
    parameter int ANGLE_WIDTH     = rvz_pkg::ANGLE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // x_in, y_in, z_in, angle from bit 0, zero pad to bytes
    input  logic [((3*COMPONENT_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // x_out, y_out, z_out from bit 0, zero pad to bytes
    output logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] o_m_tdata
);
    import rvz_pkg::*;

    localparam int CW     = COMPONENT_WIDTH;
    localparam int AW     = ANGLE_WIDTH;
    localparam int PAY_W  = 3 * CW;
    localparam int OUT_DW = ((3 * CW + 7) / 8) * 8;
    localparam int ASH    = TRIG_W - AW;

    logic ce;

    // Input stage
    t_tag                     r_s0_tag;
    logic signed [TRIG_W-1:0] r_s0_z;
    logic [PAY_W-1:0]         r_s0_pay;
    logic [TRIG_W-1:0]        ang, ang_fold;
    logic                     flip;

    // CORDIC chain
    t_tag                     tag_c [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] cx_c  [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] sy_c  [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] z_c   [CORDIC_STEPS+1];
    logic [PAY_W-1:0]         pay_c [CORDIC_STEPS+1];

    // Mix output and output buffering
    logic                     mix_valid;
    logic [PAY_W-1:0]         mix_res;
    logic                     r_out_valid, r_skid_valid;
    logic [PAY_W-1:0]         r_out, r_skid;
    logic                     out_free;

    // Pipeline advances whenever the skid entry is free
    assign ce         = !r_skid_valid;
    assign o_s_tready = ce;

    // Angle to 2^32 units per turn, fold quadrants 2 and 3 by pi
    always_comb begin
        ang      = TRIG_W'(i_s_tdata[PAY_W +: AW]) << ASH;
        flip     = ang[TRIG_W-1] ^ ang[TRIG_W-2];
        ang_fold = {ang[TRIG_W-1] ^ flip, ang[TRIG_W-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_tag <= '0;
        end else if (ce) begin
            r_s0_tag.valid <= i_s_tvalid;
            r_s0_tag.flip  <= flip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s0_z   <= $signed(ang_fold);
            r_s0_pay <= i_s_tdata[PAY_W-1:0];
        end
    end

    assign tag_c[0] = r_s0_tag;
    assign cx_c[0]  = CORDIC_GAIN;
    assign sy_c[0]  = '0;
    assign z_c[0]   = r_s0_z;
    assign pay_c[0] = r_s0_pay;

    // One stage per micro-rotation
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        rvz_cordic_stage #(
            .STEP  (g),
            .PAY_W (PAY_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_tag   (tag_c[g]),
            .i_cx    (cx_c[g]),
            .i_sy    (sy_c[g]),
            .i_z     (z_c[g]),
            .i_pay   (pay_c[g]),
            .o_tag   (tag_c[g+1]),
            .o_cx    (cx_c[g+1]),
            .o_sy    (sy_c[g+1]),
            .o_z     (z_c[g+1]),
            .o_pay   (pay_c[g+1])
        );
    end

    rvz_mix #(
        .COMPONENT_WIDTH (CW)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_tag   (tag_c[CORDIC_STEPS]),
        .i_cx    (cx_c[CORDIC_STEPS]),
        .i_sy    (sy_c[CORDIC_STEPS]),
        .i_pay   (pay_c[CORDIC_STEPS]),
        .o_valid (mix_valid),
        .o_res   (mix_res)
    );

    // Output register with one skid entry
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= mix_valid;
            end
        end else if (ce && mix_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : mix_res;
        end else if (ce) begin
            r_skid <= mix_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'(r_out);

    // Skid entry only holds an item behind a pending output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full with empty output register");

    // Input is refused only while a result is pending
    a_ready_low_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input refused without pending result");

    // Skid fills only from a stalled output
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(o_m_tvalid && !i_m_tready))
        else $error("skid filled without output stall");

    // A held skid item moves to the output as soon as it drains
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_m_tready) |=> (o_m_tvalid && !r_skid_valid))
        else $error("skid item not moved to output");

endmodule

// ===== rtl/rvz_cordic_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvz_cordic_stage
// One registered CORDIC rotation-mode micro-rotation. The vector payload
// rides along unchanged.
// ----------------------------------------------------------------------------
module rvz_cordic_stage #(
    parameter int STEP    = 0,
    parameter int PAY_W   = 72
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ce,
    input  rvz_pkg::t_tag                      i_tag,
    input  logic signed [rvz_pkg::TRIG_W-1:0]  i_cx,
    input  logic signed [rvz_pkg::TRIG_W-1:0]  i_sy,
    input  logic signed [rvz_pkg::TRIG_W-1:0]  i_z,
    input  logic        [PAY_W-1:0]            i_pay,
    output rvz_pkg::t_tag                      o_tag,
    output logic signed [rvz_pkg::TRIG_W-1:0]  o_cx,
    output logic signed [rvz_pkg::TRIG_W-1:0]  o_sy,
    output logic signed [rvz_pkg::TRIG_W-1:0]  o_z,
    output logic        [PAY_W-1:0]            o_pay
);
    import rvz_pkg::*;

    localparam logic signed [TRIG_W-1:0] ATAN = atan_step(STEP);

    t_tag                      r_tag;
    logic signed [TRIG_W-1:0]  r_cx, r_sy, r_z;
    logic        [PAY_W-1:0]   r_pay;
    logic signed [TRIG_W-1:0]  n_cx, n_sy, n_z;
    logic signed [TRIG_W-1:0]  dx, dy;

    // Shift-add rotation toward zero residual angle
    always_comb begin
        dx = i_sy >>> STEP;
        dy = i_cx >>> STEP;
        if (!i_z[TRIG_W-1]) begin
            n_cx = i_cx - dx;
            n_sy = i_sy + dy;
            n_z  = i_z - ATAN;
        end else begin
            n_cx = i_cx + dx;
            n_sy = i_sy - dy;
            n_z  = i_z + ATAN;
        end
    end

    // Control: valid cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_ce) begin
            r_tag <= i_tag;
        end
    end

    // Data
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cx  <= n_cx;
            r_sy  <= n_sy;
            r_z   <= n_z;
            r_pay <= i_pay;
        end
    end

    assign o_tag = r_tag;
    assign o_cx  = r_cx;
    assign o_sy  = r_sy;
    assign o_z   = r_z;
    assign o_pay = r_pay;

endmodule

// ===== rtl/rvz_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvz_mix
// Applies sin/cos to the vector: sign fold, split multiplies, product sums
// with rounding, recombination, saturation. Five register stages.
// ----------------------------------------------------------------------------
module rvz_mix #(
    parameter int COMPONENT_WIDTH = rvz_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ce,
    input  rvz_pkg::t_tag                      i_tag,
    input  logic signed [rvz_pkg::TRIG_W-1:0]  i_cx,
    input  logic signed [rvz_pkg::TRIG_W-1:0]  i_sy,
    input  logic [3*COMPONENT_WIDTH-1:0]       i_pay,   // x, y, z from lowest bit
    output logic                               o_valid,
    output logic [3*COMPONENT_WIDTH-1:0]       o_res    // x_out, y_out, z_out
);
    import rvz_pkg::*;

    localparam int CW   = COMPONENT_WIDTH;
    localparam int XE   = (CW > SPLIT_BITS) ? CW : SPLIT_BITS;  // extended width - 1
    localparam int HW   = XE + 1 - SPLIT_BITS;                  // high part width
    localparam int PLW  = TRIG_W + SPLIT_BITS + 1;              // low product width
    localparam int PHW  = TRIG_W + HW;                          // high product width
    localparam int LW   = PLW + 1;                              // low sum width
    localparam int HSW  = PHW + 1;                              // high sum width
    localparam int TW   = HW + 34;                              // total width
    localparam int SH   = TRIG_SHIFT - SPLIT_BITS;
    localparam int RW   = TW - SH;                              // result width

    localparam logic signed [LW-1:0] HALF = LW'(1) <<< (TRIG_SHIFT - 1);
    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    // Stage 1: quadrant fold
    t_tag                     r1_tag;
    logic signed [TRIG_W-1:0] r1_cos, r1_sin;
    logic [3*CW-1:0]          r1_pay;

    // Stage 2: split products
    t_tag                     r2_tag;
    logic signed [PLW-1:0]    r2_cxl, r2_syl, r2_sxl, r2_cyl;
    logic signed [PHW-1:0]    r2_cxh, r2_syh, r2_sxh, r2_cyh;
    logic [CW-1:0]            r2_z;

    // Stage 3: low and high sums
    t_tag                     r3_tag;
    logic signed [LW-1:0]     r3_lo_x, r3_lo_y;
    logic signed [HSW-1:0]    r3_hi_x, r3_hi_y;
    logic [CW-1:0]            r3_z;

    // Stage 4: recombined totals
    t_tag                     r4_tag;
    logic signed [TW-1:0]     r4_tot_x, r4_tot_y;
    logic [CW-1:0]            r4_z;

    // Stage 5: saturated result
    logic                     r5_valid;
    logic [3*CW-1:0]          r5_res;

    logic signed [XE:0]       xe, ye;
    logic        [SPLIT_BITS-1:0] xl, yl;
    logic signed [HW-1:0]     xh, yh;
    logic signed [RW-1:0]     res_x, res_y;
    logic signed [CW-1:0]     sat_x, sat_y;

    // Split components into an unsigned low part and a signed high part
    always_comb begin
        xe = {{(XE + 1 - CW){r1_pay[CW-1]}}, r1_pay[CW-1:0]};
        ye = {{(XE + 1 - CW){r1_pay[2*CW-1]}}, r1_pay[2*CW-1:CW]};
        xl = xe[SPLIT_BITS-1:0];
        yl = ye[SPLIT_BITS-1:0];
        xh = xe[XE:SPLIT_BITS];
        yh = ye[XE:SPLIT_BITS];
    end

    // Round by dropping six more bits, then clamp to the component range
    function automatic logic signed [CW-1:0] sat(input logic signed [RW-1:0] v);
        logic [RW-CW:0] upper;
        upper = v[RW-1:CW-1];
        if ((&upper) || !(|upper)) begin
            return v[CW-1:0];
        end
        return v[RW-1] ? MINV : MAXV;
    endfunction

    always_comb begin
        res_x = RW'(r4_tot_x >>> SH);
        res_y = RW'(r4_tot_y >>> SH);
        sat_x = sat(res_x);
        sat_y = sat(res_y);
    end

    // Control tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag   <= '0;
            r2_tag   <= '0;
            r3_tag   <= '0;
            r4_tag   <= '0;
            r5_valid <= 1'b0;
        end else if (i_ce) begin
            r1_tag   <= i_tag;
            r2_tag   <= r1_tag;
            r3_tag   <= r2_tag;
            r4_tag   <= r3_tag;
            r5_valid <= r4_tag.valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // fold: second and third quadrant negate sin and cos
            r1_cos <= i_tag.flip ? -i_cx : i_cx;
            r1_sin <= i_tag.flip ? -i_sy : i_sy;
            r1_pay <= i_pay;

            // multiply
            r2_cxl <= r1_cos * $signed({1'b0, xl});
            r2_syl <= r1_sin * $signed({1'b0, yl});
            r2_sxl <= r1_sin * $signed({1'b0, xl});
            r2_cyl <= r1_cos * $signed({1'b0, yl});
            r2_cxh <= r1_cos * xh;
            r2_syh <= r1_sin * yh;
            r2_sxh <= r1_sin * xh;
            r2_cyh <= r1_cos * yh;
            r2_z   <= r1_pay[3*CW-1:2*CW];

            // sums, rounding offset on the low half
            r3_lo_x <= LW'(r2_cxl) - LW'(r2_syl) + HALF;
            r3_lo_y <= LW'(r2_sxl) + LW'(r2_cyl) + HALF;
            r3_hi_x <= HSW'(r2_cxh) - HSW'(r2_syh);
            r3_hi_y <= HSW'(r2_sxh) + HSW'(r2_cyh);
            r3_z    <= r2_z;

            // recombine: hi + floor(lo / 2^24)
            r4_tot_x <= TW'(r3_hi_x) + TW'(r3_lo_x >>> SPLIT_BITS);
            r4_tot_y <= TW'(r3_hi_y) + TW'(r3_lo_y >>> SPLIT_BITS);
            r4_z     <= r3_z;

            r5_res   <= {r4_z, sat_y, sat_x};
        end
    end

    assign o_valid = r5_valid;
    assign o_res   = r5_res;

endmodule

// ===== test/tb_rotate_vector_about_z.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotate_vector_about_z
// Self-checking bench for the Z-axis vector rotator. A directed list of
// vectors covers the range corners, every quadrant fold and saturation,
// then about 1100 random vectors follow. Each output item is compared per
// component against an in-bench CORDIC model of the rotation, or against a
// hand-written value where a directed vector gives one, with bursty input
// traffic and a stalling output side.
module tb_rotate_vector_about_z;
    import rvz_pkg::*;

    localparam int CW    = COMPONENT_WIDTH_DEF;
    localparam int AW    = ANGLE_WIDTH_DEF;
    localparam int IN_W  = ((3*CW+AW+7)/8)*8;
    localparam int OUT_W = ((3*CW+7)/8)*8;

    localparam int NUM_RANDOM    = 1100;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int ROTATE_STEPS  = 30;

    typedef logic signed [CW-1:0] t_comp;
    typedef logic signed [AW-1:0] t_ang;

    // Stream payloads, first field in the low bits
    typedef struct packed {
        t_ang  angle;
        t_comp z;
        t_comp y;
        t_comp x;
    } t_vec_in;

    typedef struct packed {
        t_comp z;
        t_comp y;
        t_comp x;
    } t_vec_out;

    // Directed vector with optional hand-written expectation per component
    typedef struct packed {
        t_comp      x;
        t_comp      y;
        t_comp      z;
        t_ang       angle;
        logic [2:0] typed;
        t_comp      ex;
        t_comp      ey;
        t_comp      ez;
    } t_vec_case;

    localparam logic [2:0] TYPED_NONE = 3'b000;
    localparam logic [2:0] TYPED_X    = 3'b001;
    localparam logic [2:0] TYPED_Y    = 3'b010;
    localparam logic [2:0] TYPED_Z    = 3'b100;

    localparam t_comp MAXC  = {1'b0, {(CW-1){1'b1}}};
    localparam t_comp MINC  = {1'b1, {(CW-1){1'b0}}};
    localparam t_comp ZEROC = '0;
    localparam t_comp ONEC  = t_comp'(1);
    localparam t_comp NEG1C = '1;

    // Binary angles: full range is one turn
    localparam t_ang ANG_0     = '0;
    localparam t_ang ANG_45    = t_ang'(1 << (AW-3));
    localparam t_ang ANG_90    = t_ang'(1 << (AW-2));
    localparam t_ang ANG_135   = t_ang'(3 << (AW-3));
    localparam t_ang ANG_180   = {1'b1, {(AW-1){1'b0}}};
    localparam t_ang ANG_M45   = -t_ang'(1 << (AW-3));
    localparam t_ang ANG_M90   = -t_ang'(1 << (AW-2));
    localparam t_ang ANG_M135  = -t_ang'(3 << (AW-3));
    localparam t_ang ANG_MAX   = {1'b0, {(AW-1){1'b1}}};
    localparam t_ang ANG_ONE   = t_ang'(1);
    localparam t_ang ANG_M1    = '1;

    localparam int NUM_DIRECTED = 22;
    localparam t_vec_case DIRECTED [NUM_DIRECTED] = '{
        // zero vector stays zero at any angle, z passes through
        '{ZEROC, ZEROC, ZEROC, ANG_0,   TYPED_X|TYPED_Y|TYPED_Z, ZEROC, ZEROC, ZEROC},
        '{ZEROC, ZEROC, MAXC,  ANG_180, TYPED_X|TYPED_Y|TYPED_Z, ZEROC, ZEROC, MAXC},
        '{ZEROC, ZEROC, MINC,  ANG_MAX, TYPED_X|TYPED_Y|TYPED_Z, ZEROC, ZEROC, MINC},
        // corner vectors rotated by odd multiples of 45 degrees saturate one component
        '{MAXC,  MAXC,  ZEROC, ANG_45,   TYPED_Y|TYPED_Z, ZEROC, MAXC,  ZEROC},
        '{MINC,  MINC,  NEG1C, ANG_45,   TYPED_Y|TYPED_Z, ZEROC, MINC,  NEG1C},
        '{MAXC,  MINC,  ONEC,  ANG_45,   TYPED_X|TYPED_Z, MAXC,  ZEROC, ONEC},
        '{MAXC,  MAXC,  MAXC,  ANG_135,  TYPED_X|TYPED_Z, MINC,  ZEROC, MAXC},
        '{MINC,  MAXC,  MINC,  ANG_M45,  TYPED_Y|TYPED_Z, ZEROC, MAXC,  MINC},
        '{MINC,  MINC,  ZEROC, ANG_M135, TYPED_Y|TYPED_Z, ZEROC, MAXC,  ZEROC},
        // quadrant boundaries and angle extremes
        '{MAXC,  ZEROC, ONEC,  ANG_0,    TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{MAXC,  ZEROC, ONEC,  ANG_90,   TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{MAXC,  ZEROC, ONEC,  ANG_180,  TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{MAXC,  ZEROC, ONEC,  ANG_M90,  TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{MAXC,  ZEROC, ONEC,  ANG_MAX,  TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{MAXC,  ZEROC, ONEC,  ANG_M1,   TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{MAXC,  ZEROC, ONEC,  ANG_ONE,  TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{ZEROC, MINC,  ZEROC, ANG_90 - ANG_ONE, TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{ZEROC, MINC,  ZEROC, ANG_M90 - ANG_ONE, TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{MINC,  ZEROC, MAXC,  ANG_90,   TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{MINC,  MAXC,  ZEROC, ANG_180,  TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{MAXC,  MAXC,  ZEROC, ANG_0,    TYPED_NONE, ZEROC, ZEROC, ZEROC},
        '{ONEC,  NEG1C, ONEC,  ANG_135,  TYPED_NONE, ZEROC, ZEROC, ZEROC}
    };

    // atan(2^-i) in 2^32-per-turn units
    localparam longint ARCTAN_TURN32 [ROTATE_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1
    };
    localparam longint UNIT_GAIN_START = 652032874;
    localparam longint ROUND_HALF      = 64'sd1 << 29;

    // Output side stall behavior
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN,
        SINK_BLOCKS
    } t_sink_mode;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata  = '0;   // x_in, y_in, z_in, angle from bit 0
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;         // x_out, y_out, z_out from bit 0

    t_vec_out   rotated_expect [$];
    int         n_errors    = 0;
    int         n_sent      = 0;
    int         n_checked   = 0;
    int         n_saturated = 0;
    int         n_folded    = 0;
    int         cycle_count = 0;
    int         burst_left  = 0;
    t_sink_mode sink_mode   = SINK_OPEN;
    int         sink_left   = 0;
    int         sink_phase  = 0;

    rotate_vector_about_z #(
        .COMPONENT_WIDTH (CW),
        .ANGLE_WIDTH     (AW)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clamp a rounded product sum into the component range
    function automatic t_comp saturate_component(input longint v);
        if (v > longint'(MAXC))
            return MAXC;
        if (v < longint'(MINC))
            return MINC;
        return t_comp'(v);
    endfunction

    // Rotated vector: CORDIC sin/cos in Q2.30, rounded and saturated products
    function automatic t_vec_out predict_rotation(input t_vec_in v);
        logic [31:0] turn;
        logic        fold;
        longint      cosv;
        longint      sinv;
        longint      resid;
        longint      dx;
        longint      dy;
        longint      px;
        longint      py;
        t_vec_out    r;
        turn = 32'(v.angle) << (32 - AW);
        fold = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
        if (fold)
            turn = turn + 32'h8000_0000;
        resid = $signed(turn);
        cosv  = UNIT_GAIN_START;
        sinv  = 0;
        for (int i = 0; i < ROTATE_STEPS; i++) begin
            dx = sinv >>> i;
            dy = cosv >>> i;
            if (resid >= 0) begin
                cosv  = cosv - dx;
                sinv  = sinv + dy;
                resid = resid - ARCTAN_TURN32[i];
            end else begin
                cosv  = cosv + dx;
                sinv  = sinv - dy;
                resid = resid + ARCTAN_TURN32[i];
            end
        end
        if (fold) begin
            cosv = -cosv;
            sinv = -sinv;
        end
        px  = v.x;
        py  = v.y;
        r.x = saturate_component((cosv * px - sinv * py + ROUND_HALF) >>> 30);
        r.y = saturate_component((sinv * px + cosv * py + ROUND_HALF) >>> 30);
        r.z = v.z;
        return r;
    endfunction

    // Range end, zero or random value for one component
    function automatic t_comp pick_extreme();
        case ($urandom_range(0, 3))
            0:       return MINC;
            1:       return MAXC;
            2:       return ZEROC;
            default: return t_comp'($urandom);
        endcase
    endfunction

    // Drive one item in bursts, then record what it should produce
    task automatic send_vector(input t_vec_in v, input logic [2:0] typed, input t_vec_out hand);
        int       gap;
        t_vec_out want;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= IN_W'({$urandom, $urandom, $urandom});
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        burst_left--;
        want = predict_rotation(v);
        if (typed & TYPED_X)
            want.x = hand.x;
        if (typed & TYPED_Y)
            want.y = hand.y;
        if (typed & TYPED_Z)
            want.z = hand.z;
        rotated_expect.push_back(want);
        n_sent++;
        if (v.angle[AW-1] != v.angle[AW-2])
            n_folded++;
    endtask

    task automatic check_component(input string name, input t_comp want, input t_comp got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Output stall generator, picks a new random mode when its count runs out
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(20, 300);
        end else begin
            sink_left <= sink_left - 1;
        end
        sink_phase <= sink_phase + 1;
        case (sink_mode)
            SINK_OPEN:    i_m_tready <= 1'b1;
            SINK_RANDOM:  i_m_tready <= ($urandom_range(0, 3) != 0);
            SINK_PATTERN: i_m_tready <= ((sink_phase % 3) != 0);
            default:      i_m_tready <= ((sink_phase % 24) >= 16);
        endcase
    end

    // Compare each accepted output item with the oldest expectation
    always @(posedge i_clk) begin
        t_vec_out got;
        t_vec_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[$bits(t_vec_out)-1:0];
            if (rotated_expect.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected output item, expected none, got %h", $time, got);
            end else begin
                want = rotated_expect.pop_front();
                check_component("x_out", want.x, got.x);
                check_component("y_out", want.y, got.y);
                check_component("z_out", want.z, got.z);
                n_checked++;
                if (got.x == MAXC || got.x == MINC || got.y == MAXC || got.y == MINC)
                    n_saturated++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, rotated_expect.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence
    initial begin
        t_vec_in  v;
        t_vec_out hand;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed vectors
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            v.x     = DIRECTED[i].x;
            v.y     = DIRECTED[i].y;
            v.z     = DIRECTED[i].z;
            v.angle = DIRECTED[i].angle;
            hand.x  = DIRECTED[i].ex;
            hand.y  = DIRECTED[i].ey;
            hand.z  = DIRECTED[i].ez;
            send_vector(v, DIRECTED[i].typed, hand);
        end

        // random vectors, weighted toward folds and saturation
        hand = '0;
        for (int i = 0; i < NUM_RANDOM; i++) begin
            v.z     = t_comp'($urandom);
            v.angle = t_ang'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    v.x = t_comp'($urandom);
                    v.y = t_comp'($urandom);
                end
                5, 6: begin
                    v.x = t_comp'(int'($urandom_range(0, 2000)) - 1000);
                    v.y = t_comp'(int'($urandom_range(0, 2000)) - 1000);
                end
                7: begin
                    // near the corners, angle near a multiple of 45 degrees
                    v.x = MAXC - t_comp'($urandom_range(0, 4096));
                    v.y = MAXC - t_comp'($urandom_range(0, 4096));
                    if ($urandom_range(0, 1))
                        v.x = ~v.x;
                    if ($urandom_range(0, 1))
                        v.y = ~v.y;
                    v.angle = t_ang'(($urandom_range(0, 7) << (AW-3))
                                     + $urandom_range(0, 64) - 32);
                end
                8: begin
                    v.x = t_comp'($urandom);
                    v.y = t_comp'($urandom);
                    v.angle = t_ang'(($urandom_range(0, 15) << (AW-4))
                                     + $urandom_range(0, 2) - 1);
                end
                default: begin
                    v.x = pick_extreme();
                    v.y = pick_extreme();
                    v.z = pick_extreme();
                end
            endcase
            send_vector(v, TYPED_NONE, hand);
        end
        i_s_tvalid <= 1'b0;

        while (rotated_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Rotated %0d vectors (%0d directed), %0d checked, %0d in folded quadrants",
                 n_sent, NUM_DIRECTED, n_checked, n_folded);
        $display("%0d results hit the component range limit, %0d mismatches",
                 n_saturated, n_errors);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
